/* rtl/core/vcf_pkg.sv */
package vcf_pkg;

  localparam int COORD_W = 32;
  localparam int INV_W   = 24;
  localparam int IDX_W   = 15;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 48;
  localparam int CELL_W  = 25;

  localparam logic [INV_W-1:0] INV_RESET = 24'd4194304;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic                      query;
    logic                      in_range;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } cmd_t;

  // Per-voxel accumulator word; a voxel is occupied exactly when cnt is nonzero.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } entry_t;

endpackage

/* rtl/core/vcf_if.sv */
interface vcf_point_if import vcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [IDX_W-1:0]          query_voxel;

  modport source (output valid, func, coord_x, coord_y, coord_z, query_voxel, input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, query_voxel, output ready);
endinterface

interface vcf_result_if import vcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      in_range;
  logic [IDX_W-1:0]          grid_index;
  logic                      occupied;
  logic [CNT_W-1:0]          point_count;
  logic signed [COORD_W-1:0] centroid_x;
  logic signed [COORD_W-1:0] centroid_y;
  logic signed [COORD_W-1:0] centroid_z;
  logic [CNT_W-1:0]          occupied_total;

  modport source (output valid, in_range, grid_index, occupied, point_count,
                  centroid_x, centroid_y, centroid_z, occupied_total, input ready);
  modport sink   (input valid, in_range, grid_index, occupied, point_count,
                  centroid_x, centroid_y, centroid_z, occupied_total, output ready);
endinterface

/* rtl/core/vcf_front.sv */
module vcf_front import vcf_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [INV_W-1:0] inv_voxel_size,
  input  logic             clearing,
  vcf_point_if.sink        points,
  output logic             push,
  output cmd_t             push_cmd,
  input  logic             q_ready
);

  localparam int NVOX = GRID_X * GRID_Y * GRID_Z;

  logic                      s_valid;
  logic                      s_func;
  logic [IDX_W-1:0]          s_qv;
  logic signed [COORD_W-1:0] s_cx, s_cy, s_cz;
  logic signed [CELL_W-1:0]  qx, qy, qz;
  logic signed [56:0]        px, py, pz;
  logic signed [CELL_W-1:0]  ix, iz;
  logic                      pt_ok;
  logic                      accept;

  assign points.ready = !clearing && (!s_valid || q_ready);
  assign accept       = points.valid && points.ready;
  assign push         = s_valid && q_ready;

  // Q15.16 times Q8.16 gives Q.32; the top bits are the floored cell.
  assign px = points.coord_x * $signed({1'b0, inv_voxel_size});
  assign py = points.coord_y * $signed({1'b0, inv_voxel_size});
  assign pz = points.coord_z * $signed({1'b0, inv_voxel_size});

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (push) begin
      s_valid <= 1'b0;
    end
    if (accept) begin
      s_func <= points.func;
      s_qv   <= points.query_voxel;
      s_cx   <= points.coord_x;
      s_cy   <= points.coord_y;
      s_cz   <= points.coord_z;
      qx     <= px[56:32];
      qy     <= py[56:32];
      qz     <= pz[56:32];
    end
  end

  assign ix = qx + CELL_W'(GRID_X / 2);
  assign iz = qz + CELL_W'(GRID_Z / 2);
  assign pt_ok = !ix[CELL_W-1] && (ix < CELL_W'(GRID_X)) &&
                 !qy[CELL_W-1] && (qy < CELL_W'(GRID_Y)) &&
                 !iz[CELL_W-1] && (iz < CELL_W'(GRID_Z));

  always_comb begin
    push_cmd.query = s_func;
    push_cmd.cx    = s_cx;
    push_cmd.cy    = s_cy;
    push_cmd.cz    = s_cz;
    if (s_func == FUNC_QUERY) begin
      push_cmd.in_range = ({1'b0, s_qv} < (IDX_W+1)'(NVOX));
      push_cmd.idx      = s_qv;
    end else begin
      push_cmd.in_range = pt_ok;
      push_cmd.idx      = IDX_W'(ix) + IDX_W'(GRID_X) * IDX_W'(qy) +
                          IDX_W'(GRID_X * GRID_Y) * IDX_W'(iz);
    end
  end

endmodule

/* rtl/core/vcf_queue.sv */
module vcf_queue import vcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_ready,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic q_valid
);

  cmd_t       slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign pop_cmd = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) slots[wptr] <= push_cmd;
  end

endmodule

/* rtl/core/vcf_div.sv */
module vcf_div import vcf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      busy,
  output logic signed [COORD_W-1:0] quotient
);

  logic [SUM_W-1:0] acc;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic             neg;
  logic [5:0]       step;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic [SUM_W-1:0] mag;

  assign trial = {rem, acc[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // Restoring division, one quotient bit per cycle; the sign is applied at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == 6'd0) begin
      busy <= 1'b0;
    end
    if (start) begin
      acc  <= mag;
      rem  <= '0;
      dvs  <= divisor;
      neg  <= dividend[SUM_W-1];
      step <= 6'(SUM_W - 1);
    end else if (busy) begin
      rem  <= ge ? CNT_W'(trial - {1'b0, dvs}) : CNT_W'(trial);
      acc  <= {acc[SUM_W-2:0], ge};
      step <= step - 6'd1;
    end
  end

  assign quotient = neg ? COORD_W'(-acc) : COORD_W'(acc);

endmodule

/* rtl/core/vcf_back.sv */
module vcf_back import vcf_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       pop_cmd,
  output logic       pop,
  output logic       clearing,
  vcf_result_if.source results
);

  localparam int NVOX = GRID_X * GRID_Y * GRID_Z;
  localparam int AW   = $clog2(NVOX);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_UPDATE, S_DIV, S_DONE} state_t;

  state_t           state;
  cmd_t             cmd;
  logic [AW-1:0]    clr_addr;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] res_cnt;
  entry_t           mem [NVOX];
  entry_t           rdata;
  entry_t           upd;
  logic             we;
  logic [AW-1:0]    waddr;
  entry_t           wdata;
  logic             ins;
  logic             div_start;
  logic             bx, by, bz;
  logic signed [COORD_W-1:0] qx, qy, qz;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid;
  assign ins      = (cmd.query == FUNC_INSERT);

  always_comb begin
    upd = rdata;
    if (ins && rdata.cnt != COUNT_MAX) begin
      upd.cnt = rdata.cnt + CNT_W'(1);
      upd.sx  = rdata.sx + SUM_W'(cmd.cx);
      upd.sy  = rdata.sy + SUM_W'(cmd.cy);
      upd.sz  = rdata.sz + SUM_W'(cmd.cz);
    end
  end

  assign we    = clearing || (state == S_UPDATE && ins && rdata.cnt != COUNT_MAX);
  assign waddr = clearing ? clr_addr : cmd.idx[AW-1:0];
  assign wdata = clearing ? '0 : upd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[cmd.idx[AW-1:0]];
  end

  assign div_start = (state == S_UPDATE) && (upd.cnt != '0);

  vcf_div u_div_x (.clk, .rst, .start(div_start), .dividend(upd.sx), .divisor(upd.cnt),
                   .busy(bx), .quotient(qx));
  vcf_div u_div_y (.clk, .rst, .start(div_start), .dividend(upd.sy), .divisor(upd.cnt),
                   .busy(by), .quotient(qy));
  vcf_div u_div_z (.clk, .rst, .start(div_start), .dividend(upd.sz), .divisor(upd.cnt),
                   .busy(bz), .quotient(qz));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      occ           <= '0;
      results.valid <= 1'b0;
    end else begin
      // In S_DONE the result register is either reloaded or left stalled.
      if (results.valid && results.ready && state != S_DONE) results.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NVOX - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd     <= pop_cmd;
            res_cnt <= '0;
            state   <= pop_cmd.in_range ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          res_cnt <= upd.cnt;
          if (ins && rdata.cnt == '0 && occ != COUNT_MAX) occ <= occ + CNT_W'(1);
          state <= (upd.cnt != '0) ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (!bx && !by && !bz) state <= S_DONE;
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid       <= 1'b1;
            results.in_range    <= cmd.in_range;
            results.grid_index  <= (cmd.in_range || cmd.query) ? cmd.idx : '0;
            results.occupied    <= (res_cnt != '0);
            results.point_count <= res_cnt;
            results.centroid_x  <= (res_cnt != '0) ? qx : '0;
            results.centroid_y  <= (res_cnt != '0) ? qy : '0;
            results.centroid_z  <= (res_cnt != '0) ? qz : '0;
            results.occupied_total <= occ;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/voxel_grid_centroid_filter.sv */
// Voxel grid centroid filter.
// Beats arrive on the points channel (valid/ready). func selects an insert of a
// Q15.16 point or a query of a linear voxel index; every accepted beat yields
// exactly one beat on the results channel, in order.
// cfg_wen/cfg_wdata write the reciprocal voxel size; write it only while idle.
// The front takes a beat, multiplies each axis by the reciprocal, registers the
// floored cell and forms the voxel index, then pushes the classified item into a
// two-entry queue. The back reads the voxel's accumulator word, updates it on
// an insert, and runs three 48-step restoring dividers in parallel for the
// centroid. An item whose voxel holds points passes through take, read,
// update, the divide steps plus a check that they have ended, and result load;
// the back takes no new item before that load. A dropped point goes from take
// straight to result load, and a query of an empty voxel skips the divide.
// After reset the back clears the accumulator memory, one entry per cycle, all
// GRID_X*GRID_Y*GRID_Z entries (32768 by default); no beat is accepted then.
// When the receiver stalls, the result waits in the output register, the back
// holds its finished item, and the queue and front keep taking beats until full.
module voxel_grid_centroid_filter import vcf_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [INV_W-1:0] cfg_wdata,
  vcf_point_if.sink        points,
  vcf_result_if.source     results
);

  // The reciprocal voxel size, written from the configuration port.
  logic [INV_W-1:0] inv_voxel_size;

  // Handshake between the front, the queue and the back.
  logic push, q_ready, pop, q_valid, clearing;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_voxel_size <= INV_RESET;
    end else if (cfg_wen) begin
      inv_voxel_size <= cfg_wdata;
    end
  end

  vcf_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
    .clk, .rst, .inv_voxel_size, .clearing, .points,
    .push, .push_cmd, .q_ready
  );

  vcf_queue u_queue (
    .clk, .rst, .push, .push_cmd, .q_ready, .pop, .pop_cmd, .q_valid
  );

  vcf_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
    .clk, .rst, .q_valid, .pop_cmd, .pop, .clearing, .results
  );

  // The back never takes an item while the memory is still being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop) else $error("item taken during clearing pass");

  // The front only pushes into a queue with room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready) else $error("push into full queue");

  // Occupancy and count always agree on a result.
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.occupied == (results.point_count != '0)))
    else $error("occupied flag disagrees with point count");

  // A rejected item reports an empty voxel.
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.in_range) |-> (results.point_count == '0))
    else $error("out-of-range result carries a count");

endmodule
